// ===== rtl/hkpr_pkg.sv =====
// shared types, keycodes and helpers for the keyboard press and repeat block
package hkpr_pkg;

    localparam int IN_SLOTS   = 6;
    localparam int KEY_W      = 8;
    localparam int TIME_W     = 32;
    localparam int KEY_FLAG_W = 12;
    localparam int FLAGS_W    = 14;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 32;

    localparam logic [KEY_W-1:0] MOD_CTRL  = 8'h11;
    localparam logic [KEY_W-1:0] MOD_SHIFT = 8'h22;

    localparam logic [KEY_W-1:0] KC_UP     = 8'h52;
    localparam logic [KEY_W-1:0] KC_DOWN   = 8'h51;
    localparam logic [KEY_W-1:0] KC_LEFT   = 8'h50;
    localparam logic [KEY_W-1:0] KC_RIGHT  = 8'h4F;
    localparam logic [KEY_W-1:0] KC_SPACE  = 8'h2C;
    localparam logic [KEY_W-1:0] KC_ESCAPE = 8'h29;
    localparam logic [KEY_W-1:0] KC_A      = 8'h04;
    localparam logic [KEY_W-1:0] KC_D      = 8'h07;
    localparam logic [KEY_W-1:0] KC_E      = 8'h08;
    localparam logic [KEY_W-1:0] KC_Q      = 8'h14;
    localparam logic [KEY_W-1:0] KC_S      = 8'h16;
    localparam logic [KEY_W-1:0] KC_W      = 8'h1A;

    localparam logic [TIME_W-1:0] DELAY_RESET    = 32'd400000;
    localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd80000;

    typedef enum logic [1:0] {
        MODE_REPORT     = 2'd0,
        MODE_POLL       = 2'd1,
        MODE_DISCONNECT = 2'd2
    } t_mode;

    typedef enum logic [0:0] {
        CFG_DELAY    = 1'b0,
        CFG_INTERVAL = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [KEY_W-1:0]      code;
        logic                  is_new;
        logic                  match_held;
        logic [KEY_FLAG_W-1:0] key_flags;
    } t_lane_res;

    typedef struct packed {
        logic                  new_found;
        logic [KEY_W-1:0]      new_code;
        logic                  held_present;
        logic [KEY_FLAG_W-1:0] key_flags;
    } t_merge_res;

    function automatic logic [KEY_FLAG_W-1:0] key_flag_of(input logic [KEY_W-1:0] code);
        logic [KEY_FLAG_W-1:0] f;
        f = '0;
        unique case (code)
            KC_A:      f[0]  = 1'b1;
            KC_D:      f[1]  = 1'b1;
            KC_E:      f[2]  = 1'b1;
            KC_Q:      f[3]  = 1'b1;
            KC_S:      f[4]  = 1'b1;
            KC_W:      f[5]  = 1'b1;
            KC_UP:     f[6]  = 1'b1;
            KC_DOWN:   f[7]  = 1'b1;
            KC_LEFT:   f[8]  = 1'b1;
            KC_RIGHT:  f[9]  = 1'b1;
            KC_SPACE:  f[10] = 1'b1;
            KC_ESCAPE: f[11] = 1'b1;
            default:   f = '0;
        endcase
        return f;
    endfunction

    function automatic logic is_suppressed(input logic [KEY_W-1:0] code,
                                           input logic [KEY_W-1:0] modifier);
        return ((modifier & MOD_CTRL) != '0) && (code == KC_UP || code == KC_DOWN);
    endfunction

endpackage

// ===== rtl/hkpr_lane.sv =====
// per-slot lane: new-key check against the previous report, held match, flag decode
module hkpr_lane #(
    parameter int N = 6
) (
    input  logic [7:0]                 i_key,
    input  logic [N-1:0][7:0]          i_last_keys,
    input  logic [7:0]                 i_held_code,
    output hkpr_pkg::t_lane_res        o_res
);
    import hkpr_pkg::*;

    logic [N-1:0] w_seen;

    always_comb begin
        for (int j = 0; j < N; j++) begin
            w_seen[j] = (i_last_keys[j] == i_key);
        end
        o_res.code       = i_key;
        o_res.is_new     = (i_key != '0) && !(|w_seen);
        o_res.match_held = (i_held_code != '0) && (i_key == i_held_code);
        o_res.key_flags  = key_flag_of(i_key);
    end

endmodule

// ===== rtl/hkpr_merge.sv =====
// merge of lane results: first new key in slot order, held key presence, flag word
module hkpr_merge #(
    parameter int N = 6
) (
    input  hkpr_pkg::t_lane_res  i_lanes [N],
    output hkpr_pkg::t_merge_res o_res
);
    import hkpr_pkg::*;

    always_comb begin
        o_res.new_found    = 1'b0;
        o_res.new_code     = '0;
        o_res.held_present = 1'b0;
        o_res.key_flags    = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_lanes[i].is_new) begin
                o_res.new_found = 1'b1;
                o_res.new_code  = i_lanes[i].code;
            end
            o_res.held_present = o_res.held_present | i_lanes[i].match_held;
            o_res.key_flags    = o_res.key_flags | i_lanes[i].key_flags;
        end
    end

endmodule

// ===== rtl/hid_key_press_and_repeat.sv =====
// keyboard poll processor: fresh key press, typematic repeat and held-key flags
//
// input channel (i_s_*): one keyboard poll per item; tuser carries the mode
// (new report, poll without report, disconnect), tdata the modifier byte, six
// keycode slots and the microsecond timestamp
// output channel (o_m_*): exactly one result per poll; tuser carries the event
// valid and repeat flags, tdata the keycode, modifier and held-key flag word
// config port: i_cfg_we writes repeat delay (index 0) or interval (index 1);
// the user must write only while no item is in flight; the block does not enforce it
// output: the result is registered and valid in the cycle after its poll is accepted
// throughput: one poll per cycle while results are taken; all report slots are
// compared in parallel lanes against the stored report, and the two timestamp
// compares close in the same cycle as the repeat state update
// stall: the result sits in an output register; while it is not taken a new
// poll is accepted only in the cycle that the result leaves
// reset: synchronous, active low; stored report and repeat state cleared,
// delay 400000 us and interval 80000 us, output channel empty
module hid_key_press_and_repeat #(
    parameter int REPORT_SLOTS = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // modifier_bits, key_slot0..key_slot5, now_us
    input  logic [hkpr_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // mode
    input  logic [1:0]                       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // event_keycode, event_modifier, held_flags, zero pad
    output logic [hkpr_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // event_valid, event_is_repeat
    output logic [1:0]                       o_m_tuser,
    input  logic                             i_cfg_we,
    input  logic [0:0]                       i_cfg_addr,
    input  logic [31:0]                      i_cfg_wdata
);
    import hkpr_pkg::*;

    logic [TIME_W-1:0]                r_delay, r_interval;
    logic [REPORT_SLOTS-1:0][KEY_W-1:0] r_last_keys, n_last_keys;
    logic [KEY_W-1:0]                 r_last_mod, n_last_mod;
    logic [KEY_W-1:0]                 r_held_code, n_held_code;
    logic [KEY_W-1:0]                 r_held_mod, n_held_mod;
    logic [TIME_W-1:0]                r_since, n_since;
    logic [TIME_W-1:0]                r_emit, n_emit;
    logic                             r_out_valid;
    logic                             r_out_ev, n_out_ev;
    logic                             r_out_rep, n_out_rep;
    logic [KEY_W-1:0]                 r_out_code, n_out_code;
    logic [KEY_W-1:0]                 r_out_mod, n_out_mod;
    logic [FLAGS_W-1:0]               r_out_flags, n_out_flags;

    t_mode                            w_mode;
    logic                             w_accept;
    logic [KEY_W-1:0]                 w_in_mod;
    logic [TIME_W-1:0]                w_now;
    logic [REPORT_SLOTS-1:0][KEY_W-1:0] w_cur_keys, w_act_keys;
    logic [KEY_W-1:0]                 w_act_mod;
    t_lane_res                        w_lanes [REPORT_SLOTS];
    t_merge_res                       w_merge;
    logic                             w_fresh, w_restart, w_due;

    assign w_mode     = t_mode'(i_s_tuser);
    assign w_in_mod   = i_s_tdata[7:0];
    assign w_now      = i_s_tdata[87:56];
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    genvar g;
    generate
        for (g = 0; g < REPORT_SLOTS; g++) begin : g_lane
            if (g < IN_SLOTS) begin : g_used
                assign w_cur_keys[g] = i_s_tdata[KEY_W*(g+1) +: KEY_W];
            end else begin : g_empty
                assign w_cur_keys[g] = '0;
            end
            assign w_act_keys[g] = (w_mode == MODE_REPORT) ? w_cur_keys[g] : r_last_keys[g];
            hkpr_lane #(.N(REPORT_SLOTS)) u_lane (
                .i_key       (w_act_keys[g]),
                .i_last_keys (r_last_keys),
                .i_held_code (r_held_code),
                .o_res       (w_lanes[g])
            );
        end
    endgenerate

    hkpr_merge #(.N(REPORT_SLOTS)) u_merge (
        .i_lanes (w_lanes),
        .o_res   (w_merge)
    );

    assign w_act_mod = (w_mode == MODE_REPORT) ? w_in_mod : r_last_mod;
    assign w_fresh   = (w_mode == MODE_REPORT) && w_merge.new_found;
    assign w_restart = w_merge.held_present && (w_act_mod != r_held_mod);

    always_comb begin
        if (w_restart) begin
            w_due = (r_delay == '0) && (r_interval == '0);
        end else begin
            w_due = ((w_now - r_since) >= r_delay) && ((w_now - r_emit) >= r_interval);
        end
    end

    always_comb begin
        n_last_keys = r_last_keys;
        n_last_mod  = r_last_mod;
        n_held_code = r_held_code;
        n_held_mod  = r_held_mod;
        n_since     = r_since;
        n_emit      = r_emit;
        n_out_ev    = 1'b0;
        n_out_rep   = 1'b0;
        n_out_code  = '0;
        n_out_mod   = '0;
        n_out_flags = '0;
        if (w_mode == MODE_DISCONNECT) begin
            n_last_keys = '0;
            n_last_mod  = '0;
            n_held_code = '0;
            n_held_mod  = '0;
            n_since     = '0;
            n_emit      = '0;
        end else begin
            if (w_mode == MODE_REPORT) begin
                n_last_keys = w_cur_keys;
                n_last_mod  = w_in_mod;
            end
            n_out_flags = {w_merge.key_flags,
                           |(w_act_mod & MOD_CTRL),
                           |(w_act_mod & MOD_SHIFT)};
            if (w_fresh) begin
                n_held_code = w_merge.new_code;
                n_held_mod  = w_in_mod;
                n_since     = w_now;
                n_emit      = w_now;
                if (!is_suppressed(w_merge.new_code, w_in_mod)) begin
                    n_out_ev   = 1'b1;
                    n_out_code = w_merge.new_code;
                    n_out_mod  = w_in_mod;
                end
            end else if (r_held_code != '0) begin
                if (!w_merge.held_present) begin
                    n_held_code = '0;
                    n_held_mod  = '0;
                    n_since     = '0;
                    n_emit      = '0;
                end else begin
                    if (w_restart) begin
                        n_held_mod = w_act_mod;
                        n_since    = w_now;
                        n_emit     = w_now;
                    end
                    if (w_due) begin
                        n_emit = w_now;
                        if (!is_suppressed(r_held_code, w_act_mod)) begin
                            n_out_ev   = 1'b1;
                            n_out_rep  = 1'b1;
                            n_out_code = r_held_code;
                            n_out_mod  = w_act_mod;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= DELAY_RESET;
            r_interval  <= INTERVAL_RESET;
            r_last_keys <= '0;
            r_last_mod  <= '0;
            r_held_code <= '0;
            r_held_mod  <= '0;
            r_since     <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_addr))
                    CFG_DELAY:    r_delay    <= i_cfg_wdata;
                    CFG_INTERVAL: r_interval <= i_cfg_wdata;
                endcase
            end
            if (w_accept) begin
                r_last_keys <= n_last_keys;
                r_last_mod  <= n_last_mod;
                r_held_code <= n_held_code;
                r_held_mod  <= n_held_mod;
                r_since     <= n_since;
                r_emit      <= n_emit;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_ev    <= n_out_ev;
            r_out_rep   <= n_out_rep;
            r_out_code  <= n_out_code;
            r_out_mod   <= n_out_mod;
            r_out_flags <= n_out_flags;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_flags, r_out_mod, r_out_code};
    assign o_m_tuser  = {r_out_rep, r_out_ev};

    a_repeat_is_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rep) |-> r_out_ev)
        else $error("repeat flag without event");

    a_event_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ev) |-> (r_out_code != '0))
        else $error("event with empty keycode");

    a_repeat_of_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rep) |-> (r_held_code == r_out_code))
        else $error("repeat keycode differs from held key");

    a_disconnect_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == MODE_DISCONNECT) |=>
            (r_held_code == '0 && r_last_mod == '0 && r_out_flags == '0 && !r_out_ev))
        else $error("disconnect left state behind");

endmodule
